// ===== rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Implication checked at every rising edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Plain condition checked at every rising edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define ASSERT_ALWAYS(label, clk, rst_n, cond)
`endif
`endif

// ===== rtl/fwsc_pkg.sv =====
`default_nettype none
package fwsc_pkg;

  localparam int DIST_W  = 12;
  localparam int SPEED_W = 12;
  localparam int MEM_W   = 16;              // Q1.15 membership, 32768 = 1.0
  localparam int DEN_W   = 17;              // weight sums
  localparam int NUM_W   = DEN_W + SPEED_W; // weighted level sums
  localparam int CFG_IDX_W = 2;

  localparam logic [MEM_W-1:0] Q_ONE = MEM_W'(32768);

  // Both trapezoids of both readings have edges 150 units wide.
  // MAGIC is ceil(32768 * 2^20 / 150); the error is below one part in 75.
  localparam logic [27:0] MAGIC = 28'd229064923;

  localparam logic [DIST_W-1:0] SIDE_A  = DIST_W'(500);
  localparam logic [DIST_W-1:0] SIDE_B  = DIST_W'(650);
  localparam logic [DIST_W-1:0] SIDE_C  = DIST_W'(750);
  localparam logic [DIST_W-1:0] SIDE_E  = DIST_W'(900);
  localparam logic [DIST_W-1:0] AHEAD_A = DIST_W'(600);
  localparam logic [DIST_W-1:0] AHEAD_B = DIST_W'(750);
  localparam logic [DIST_W-1:0] AHEAD_C = DIST_W'(850);
  localparam logic [DIST_W-1:0] AHEAD_E = DIST_W'(1000);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SLOW   = 2'd0,
    CFG_MEDIUM = 2'd1,
    CFG_FAST   = 2'd2
  } cfg_idx_t;

  typedef logic [1:0] lvl_sel_t;
  localparam lvl_sel_t LV_SLOW = 2'd0;
  localparam lvl_sel_t LV_MED  = 2'd1;
  localparam lvl_sel_t LV_FAST = 2'd2;

  // Consequent level per rule, indexed [side term][ahead term].
  localparam lvl_sel_t LEFT_RULE [3][3] = '{
    '{LV_SLOW, LV_MED, LV_FAST},
    '{LV_SLOW, LV_MED, LV_FAST},
    '{LV_SLOW, LV_MED, LV_FAST}};
  localparam lvl_sel_t RIGHT_RULE [3][3] = '{
    '{LV_FAST, LV_FAST, LV_SLOW},
    '{LV_MED,  LV_MED,  LV_MED},
    '{LV_FAST, LV_SLOW, LV_SLOW}};

  typedef logic [2:0][MEM_W-1:0]   mem3_t;
  typedef logic [2:0][SPEED_W-1:0] levels_t;

  typedef struct packed {
    logic [DIST_W-1:0] side_distance;
    logic [DIST_W-1:0] ahead_distance;
  } in_word_t;

  typedef struct packed {
    logic [SPEED_W-1:0] left_wheel_speed;
    logic [SPEED_W-1:0] right_wheel_speed;
  } out_word_t;

  // floor(x * 32768 / 150) for 0 <= x < 150.
  function automatic logic [MEM_W-1:0] edge_frac(input logic [7:0] x);
    logic [35:0] prod;
    prod = {28'd0, x} * {8'd0, MAGIC};
    return prod[35:20];
  endfunction

  // Low, medium and high memberships of one reading.
  function automatic mem3_t fuzzify(input logic [DIST_W-1:0] d,
                                    input logic [DIST_W-1:0] a,
                                    input logic [DIST_W-1:0] b,
                                    input logic [DIST_W-1:0] c,
                                    input logic [DIST_W-1:0] e);
    mem3_t m;
    if (d <= a) m[0] = Q_ONE;
    else if (d >= b) m[0] = '0;
    else m[0] = edge_frac(8'(b - d));

    if (d <= a || d >= e) m[1] = '0;
    else if (d >= b && d <= c) m[1] = Q_ONE;
    else if (d < b) m[1] = edge_frac(8'(d - a));
    else m[1] = edge_frac(8'(e - d));

    if (d >= e) m[2] = Q_ONE;
    else if (d <= c) m[2] = '0;
    else m[2] = edge_frac(8'(d - c));
    return m;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/fwsc_fuzz.sv =====
`default_nettype none
module fwsc_fuzz import fwsc_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_v,
  input  wire in_word_t in_word,
  output logic          v_r,
  output mem3_t         ms_r,
  output mem3_t         mf_r
);

  // Valid bit of the membership stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= in_v;
    end
  end

  // Memberships of both readings.
  always_ff @(posedge clk) begin
    ms_r <= fuzzify(in_word.side_distance, SIDE_A, SIDE_B, SIDE_C, SIDE_E);
    mf_r <= fuzzify(in_word.ahead_distance, AHEAD_A, AHEAD_B, AHEAD_C, AHEAD_E);
  end

endmodule
`default_nettype wire

// ===== rtl/fwsc_rules.sv =====
`default_nettype none
module fwsc_rules import fwsc_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_v,
  input  wire mem3_t   ms,
  input  wire mem3_t   mf,
  input  wire levels_t lv,
  output logic         v_r,
  output logic [NUM_W-1:0] num_l_r,
  output logic [NUM_W-1:0] num_r_r,
  output logic [DEN_W-1:0] den_r
);

  logic [MEM_W-1:0] w_r [3][3];
  logic [MEM_W-1:0] w_nxt [3][3];
  logic [DEN_W-1:0] den_nxt, den_b_r;
  logic [DEN_W-1:0] sl_nxt [3];
  logic [DEN_W-1:0] sr_nxt [3];
  logic [DEN_W-1:0] sl_r [3];
  logic [DEN_W-1:0] sr_r [3];
  logic [NUM_W-1:0] num_l_nxt, num_r_nxt;
  logic [2:0] v_p_r;

  // Rule weights: product of the two memberships, back in Q1.15.
  always_comb begin
    logic [2*MEM_W-1:0] p;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        p = ms[i] * mf[j];
        w_nxt[i][j] = p[MEM_W+14:15];
      end
    end
  end

  // Total weight and the weight gathered under each speed level.
  always_comb begin
    den_nxt = '0;
    for (int k = 0; k < 3; k++) begin
      sl_nxt[k] = '0;
      sr_nxt[k] = '0;
    end
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        den_nxt = den_nxt + DEN_W'(w_r[i][j]);
        sl_nxt[LEFT_RULE[i][j]]  = sl_nxt[LEFT_RULE[i][j]] + DEN_W'(w_r[i][j]);
        sr_nxt[RIGHT_RULE[i][j]] = sr_nxt[RIGHT_RULE[i][j]] + DEN_W'(w_r[i][j]);
      end
    end
  end

  // Weighted level sums for both wheels.
  always_comb begin
    num_l_nxt = '0;
    num_r_nxt = '0;
    for (int k = 0; k < 3; k++) begin
      num_l_nxt = num_l_nxt + NUM_W'(sl_r[k]) * NUM_W'(lv[k]);
      num_r_nxt = num_r_nxt + NUM_W'(sr_r[k]) * NUM_W'(lv[k]);
    end
  end

  // Valid bits of the three stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_p_r <= '0;
    end else begin
      v_p_r <= {v_p_r[1:0], in_v};
    end
  end
  assign v_r = v_p_r[2];

  // Payload registers.
  always_ff @(posedge clk) begin
    w_r     <= w_nxt;
    sl_r    <= sl_nxt;
    sr_r    <= sr_nxt;
    den_b_r <= den_nxt;
    num_l_r <= num_l_nxt;
    num_r_r <= num_r_nxt;
    den_r   <= den_b_r;
  end

endmodule
`default_nettype wire

// ===== rtl/fwsc_div.sv =====
`default_nettype none
`include "assert_macros.svh"
module fwsc_div import fwsc_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_v,
  input  wire logic [NUM_W-1:0] num_l,
  input  wire logic [NUM_W-1:0] num_r,
  input  wire logic [DEN_W-1:0] den,
  output logic                  out_v,
  output out_word_t             out_word
);

  // One quotient bit per stage, most significant first.
  logic               v_r     [SPEED_W];
  logic [NUM_W-1:0]   rl_r    [SPEED_W];
  logic [NUM_W-1:0]   rr_r    [SPEED_W];
  logic [DEN_W-1:0]   d_r     [SPEED_W];
  logic [SPEED_W-1:0] ql_r    [SPEED_W];
  logic [SPEED_W-1:0] qr_r    [SPEED_W];
  logic [NUM_W-1:0]   rl_nxt  [SPEED_W];
  logic [NUM_W-1:0]   rr_nxt  [SPEED_W];
  logic [DEN_W-1:0]   d_nxt   [SPEED_W];
  logic [SPEED_W-1:0] ql_nxt  [SPEED_W];
  logic [SPEED_W-1:0] qr_nxt  [SPEED_W];
  logic               v_nxt   [SPEED_W];

  // Restoring division step of each stage.
  always_comb begin
    logic [NUM_W-1:0]   al, ar, trial;
    logic [DEN_W-1:0]   dd;
    logic [SPEED_W-1:0] pl, pr;
    logic               vv;
    for (int k = 0; k < SPEED_W; k++) begin
      if (k == 0) begin
        al = num_l; ar = num_r; dd = den; pl = '0; pr = '0; vv = in_v;
      end else begin
        al = rl_r[k-1]; ar = rr_r[k-1]; dd = d_r[k-1];
        pl = ql_r[k-1]; pr = qr_r[k-1]; vv = v_r[k-1];
      end
      trial = NUM_W'(dd) << (SPEED_W - 1 - k);
      if (al >= trial) begin
        al = al - trial;
        pl[SPEED_W-1-k] = 1'b1;
      end
      if (ar >= trial) begin
        ar = ar - trial;
        pr[SPEED_W-1-k] = 1'b1;
      end
      rl_nxt[k] = al;
      rr_nxt[k] = ar;
      d_nxt[k]  = dd;
      ql_nxt[k] = pl;
      qr_nxt[k] = pr;
      v_nxt[k]  = vv;
    end
  end

  // Valid bits travel with each stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < SPEED_W; k++) v_r[k] <= 1'b0;
    end else begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rl_r <= rl_nxt;
    rr_r <= rr_nxt;
    d_r  <= d_nxt;
    ql_r <= ql_nxt;
    qr_r <= qr_nxt;
  end

  // A zero weight sum gives zero speeds.
  logic den_zero;
  assign den_zero = (d_r[SPEED_W-1] == '0);
  assign out_v = v_r[SPEED_W-1];
  assign out_word.left_wheel_speed  = den_zero ? '0 : ql_r[SPEED_W-1];
  assign out_word.right_wheel_speed = den_zero ? '0 : qr_r[SPEED_W-1];

  // The remainders left after the last step are below the divisor.
  `ASSERT_IMPL(a_rem_l, clk, rst_n, out_v && !den_zero, rl_r[SPEED_W-1] < NUM_W'(d_r[SPEED_W-1]))
  `ASSERT_IMPL(a_rem_r, clk, rst_n, out_v && !den_zero, rr_r[SPEED_W-1] < NUM_W'(d_r[SPEED_W-1]))

endmodule
`default_nettype wire

// ===== rtl/fuzzy_wall_follow_speed_controller.sv =====
`default_nettype none
`include "assert_macros.svh"
// Fuzzy wall-following speed controller. Issue one reading pair per cycle by raising
// start; busy is always low, so every cycle can take a word. Each word gives exactly
// one result, shown on out_data for a single cycle with out_valid high, after it passes
// one membership stage, three rule stages (weights, level sums, weighted sums) and
// the 12-stage divider, which gives one quotient bit per stage. The receiver
// cannot stall the output and must take each result in the cycle it appears. Write
// the speed levels only while no word is in flight.
module fuzzy_wall_follow_speed_controller import fwsc_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  output logic                      busy,
  input  wire in_word_t             in_data,
  output logic                      out_valid,
  output out_word_t                 out_data,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx,
  input  wire logic [SPEED_W-1:0]   cfg_wdata
);

  levels_t lv_r;
  logic    acc;

  assign busy = 1'b0;
  assign acc  = start && !busy;

  // Speed level registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lv_r <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_SLOW:   lv_r[LV_SLOW] <= cfg_wdata;
        CFG_MEDIUM: lv_r[LV_MED]  <= cfg_wdata;
        CFG_FAST:   lv_r[LV_FAST] <= cfg_wdata;
        default:    ;
      endcase
    end
  end

  logic  f_v;
  mem3_t ms, mf;

  fwsc_fuzz u_fuzz (
    .clk(clk), .rst_n(rst_n), .in_v(acc), .in_word(in_data),
    .v_r(f_v), .ms_r(ms), .mf_r(mf)
  );

  logic             r_v;
  logic [NUM_W-1:0] num_l, num_r;
  logic [DEN_W-1:0] den;

  fwsc_rules u_rules (
    .clk(clk), .rst_n(rst_n), .in_v(f_v), .ms(ms), .mf(mf), .lv(lv_r),
    .v_r(r_v), .num_l_r(num_l), .num_r_r(num_r), .den_r(den)
  );

  fwsc_div u_div (
    .clk(clk), .rst_n(rst_n), .in_v(r_v), .num_l(num_l), .num_r(num_r),
    .den(den), .out_v(out_valid), .out_word(out_data)
  );

  // A weighted average never exceeds the largest level.
  logic [SPEED_W-1:0] lv_max;
  always_comb begin
    lv_max = lv_r[0];
    if (lv_r[1] > lv_max) lv_max = lv_r[1];
    if (lv_r[2] > lv_max) lv_max = lv_r[2];
  end

  `ASSERT_IMPL(a_left_max, clk, rst_n, out_valid, out_data.left_wheel_speed <= lv_max)
  `ASSERT_IMPL(a_right_max, clk, rst_n, out_valid, out_data.right_wheel_speed <= lv_max)
  `ASSERT_ALWAYS(a_never_busy, clk, rst_n, !busy)

endmodule
`default_nettype wire
